### rtl/core/vtb_pkg.sv
// Shared types and constants of the vertex transform bake unit.
package vtb_pkg;

  // Working width of a vector entering the normaliser.
  localparam int NORM_W = 52;
  // Shift-count width for the normaliser's leading-one search.
  localparam int MSB_W = $clog2(NORM_W);
  // Square root stages (one result bit each) and divider stages (one quotient bit each).
  localparam int SQRT_STEPS = 31;
  localparam int DIV_STEPS = 15;
  // Normaliser stages: five scaling and squaring stages, the root, one set-up stage,
  // the divider and one sign stage.
  localparam int NORM_LAT = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;
  // Front stages, two normalisers, tangent stages and the output register.
  localparam int TOTAL_LAT = 6 + NORM_LAT + 7 + NORM_LAT + 1;

  localparam logic signed [15:0] VEC_ONE = 16'sd16384;
  localparam logic [33:0] TAN_EPS = 34'd4503;

  localparam logic [47:0] ROW0_RST = 48'h0000_0000_1000;
  localparam logic [47:0] ROW1_RST = 48'h0000_1000_0000;
  localparam logic [47:0] ROW2_RST = 48'h1000_0000_0000;
  localparam logic [39:0] MIN_DET_RST = 40'd7;

  // Cyclic neighbours of a matrix index, used to form cofactors.
  localparam int NXT1 [3] = '{1, 2, 0};
  localparam int NXT2 [3] = '{2, 0, 1};

  typedef enum logic [2:0] {
    REG_ROW0,
    REG_ROW1,
    REG_ROW2,
    REG_TR_X,
    REG_TR_Y,
    REG_TR_Z,
    REG_MIN_DET
  } cfg_reg_e;

  typedef logic [2:0][NORM_W-1:0] nvec_t;
  typedef logic [2:0][15:0] uvec_t;

endpackage

### rtl/core/vtb_norm.sv
// Pipelined vector normaliser: scaling, squared length, square root and divider.
module vtb_norm import vtb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  nvec_t vec_i,
  output logic  valid_o,
  output uvec_t vec_o
);

  localparam int MagW = 30;
  localparam int SqW = 2 * MagW + 2;
  localparam int RootW = SqW + 1;
  localparam int LenW = 32;
  localparam int NumW = MagW + 15;
  localparam int RemW = LenW + 1;
  localparam logic [MSB_W-1:0] TopBit = MSB_W'(29);

  logic [NORM_LAT-1:0] vld_q;

  // Stage 1: largest magnitude and its leading one.
  logic [NORM_W-1:0] mag1 [3];
  logic [NORM_W-1:0] max1;
  logic [MSB_W-1:0]  msb1;
  nvec_t             s1_v_q;
  logic [MSB_W-1:0]  s1_msb_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag1[i] = vec_i[i][NORM_W-1] ? (~vec_i[i]) + NORM_W'(1) : vec_i[i];
    end
    max1 = mag1[0];
    if (mag1[1] > max1) max1 = mag1[1];
    if (mag1[2] > max1) max1 = mag1[2];
    msb1 = '0;
    for (int b = 0; b < NORM_W; b++) begin
      if (max1[b]) msb1 = MSB_W'(b);
    end
  end

  // Stage 2: coarse shift that puts the leading one at bit 29.
  logic signed [NORM_W-1:0] sh2;
  logic signed [30:0]       v2 [3];
  logic signed [30:0]       s2_v_q [3];

  always_comb begin
    sh2 = '0;
    for (int i = 0; i < 3; i++) begin
      if (s1_msb_q > TopBit) begin
        sh2 = $signed(s1_v_q[i]) >>> (s1_msb_q - TopBit);
      end else begin
        sh2 = $signed(s1_v_q[i]) <<< (TopBit - s1_msb_q);
      end
      v2[i] = sh2[30:0];
    end
  end

  // Stage 3: flooring a negative entry can leave exactly -2^30, which needs one more step.
  logic              fix3;
  logic signed [30:0] v3 [3];
  logic signed [30:0] n3 [3];
  logic [MagW-1:0]   s3_a_q [3];
  logic              s3_neg_q [3];

  always_comb begin
    fix3 = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (s2_v_q[i] == {1'b1, 30'b0}) fix3 = 1'b1;
    end
    for (int i = 0; i < 3; i++) begin
      v3[i] = fix3 ? (s2_v_q[i] >>> 1) : s2_v_q[i];
      n3[i] = -v3[i];
    end
  end

  // Stages 4 and 5: squares and squared length.
  logic [2*MagW-1:0] s4_sq_q [3];
  logic [MagW-1:0]   s4_a_q [3];
  logic              s4_neg_q [3];

  // Square root pipeline, index 0 is the stage 5 register.
  logic [SqW-1:0]   rt_x_q [SQRT_STEPS+1];
  logic [RootW-1:0] rt_r_q [SQRT_STEPS+1];
  logic [MagW-1:0]  rt_a_q [SQRT_STEPS+1][3];
  logic             rt_neg_q [SQRT_STEPS+1][3];
  logic [SqW-1:0]   rt_x_d [SQRT_STEPS];
  logic [RootW-1:0] rt_r_d [SQRT_STEPS];

  always_comb begin
    logic [RootW-1:0] bit_v;
    logic [RootW-1:0] trial;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      bit_v = RootW'(1) << (2 * (SQRT_STEPS - 1 - k));
      trial = rt_r_q[k] + bit_v;
      if (RootW'(rt_x_q[k]) >= trial) begin
        rt_x_d[k] = rt_x_q[k] - trial[SqW-1:0];
        rt_r_d[k] = (rt_r_q[k] >> 1) + bit_v;
      end else begin
        rt_x_d[k] = rt_x_q[k];
        rt_r_d[k] = rt_r_q[k] >> 1;
      end
    end
  end

  // Divider pipeline: (a * 2^14 + len / 2) / len, one quotient bit a stage.
  logic [LenW-1:0]      len_s;
  logic [NumW-1:0]      num_s [3];
  logic [RemW-1:0]      dv_rem_q [DIV_STEPS+1][3];
  logic [DIV_STEPS-1:0] dv_low_q [DIV_STEPS+1][3];
  logic [DIV_STEPS-1:0] dv_quo_q [DIV_STEPS+1][3];
  logic                 dv_neg_q [DIV_STEPS+1][3];
  logic [LenW-1:0]      dv_len_q [DIV_STEPS+1];
  logic [RemW-1:0]      dv_rem_d [DIV_STEPS][3];
  logic [DIV_STEPS-1:0] dv_quo_d [DIV_STEPS][3];

  always_comb begin
    len_s = rt_r_q[SQRT_STEPS][LenW-1:0];
    for (int i = 0; i < 3; i++) begin
      num_s[i] = NumW'({rt_a_q[SQRT_STEPS][i], 14'b0}) + NumW'(len_s >> 1);
    end
  end

  always_comb begin
    logic [RemW-1:0] trial;
    for (int j = 0; j < DIV_STEPS; j++) begin
      for (int i = 0; i < 3; i++) begin
        trial = {dv_rem_q[j][i][LenW-1:0], dv_low_q[j][i][DIV_STEPS-1-j]};
        dv_quo_d[j][i] = dv_quo_q[j][i];
        if (trial >= RemW'(dv_len_q[j])) begin
          dv_rem_d[j][i] = trial - RemW'(dv_len_q[j]);
          dv_quo_d[j][i][DIV_STEPS-1-j] = 1'b1;
        end else begin
          dv_rem_d[j][i] = trial;
        end
      end
    end
  end

  uvec_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NORM_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_v_q   <= vec_i;
    s1_msb_q <= msb1;
    s2_v_q   <= v2;
    for (int i = 0; i < 3; i++) begin
      s3_a_q[i]   <= v3[i][30] ? n3[i][MagW-1:0] : v3[i][MagW-1:0];
      s3_neg_q[i] <= v3[i][30];
      s4_sq_q[i]  <= s3_a_q[i] * s3_a_q[i];
      s4_a_q[i]   <= s3_a_q[i];
      s4_neg_q[i] <= s3_neg_q[i];
    end
    rt_x_q[0] <= SqW'(s4_sq_q[0]) + SqW'(s4_sq_q[1]) + SqW'(s4_sq_q[2]);
    rt_r_q[0] <= '0;
    rt_a_q[0] <= s4_a_q;
    rt_neg_q[0] <= s4_neg_q;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      rt_x_q[k+1]   <= rt_x_d[k];
      rt_r_q[k+1]   <= rt_r_d[k];
      rt_a_q[k+1]   <= rt_a_q[k];
      rt_neg_q[k+1] <= rt_neg_q[k];
    end
    dv_len_q[0] <= len_s;
    for (int i = 0; i < 3; i++) begin
      dv_rem_q[0][i] <= RemW'(num_s[i][NumW-1:DIV_STEPS]);
      dv_low_q[0][i] <= num_s[i][DIV_STEPS-1:0];
      dv_quo_q[0][i] <= '0;
      dv_neg_q[0][i] <= rt_neg_q[SQRT_STEPS][i];
    end
    for (int j = 0; j < DIV_STEPS; j++) begin
      dv_len_q[j+1] <= dv_len_q[j];
      dv_rem_q[j+1] <= dv_rem_d[j];
      dv_quo_q[j+1] <= dv_quo_d[j];
      dv_low_q[j+1] <= dv_low_q[j];
      dv_neg_q[j+1] <= dv_neg_q[j];
    end
    for (int i = 0; i < 3; i++) begin
      out_q[i] <= dv_neg_q[DIV_STEPS][i] ? 16'(-(16'(dv_quo_q[DIV_STEPS][i])))
                                         : 16'(dv_quo_q[DIV_STEPS][i]);
    end
  end

  assign valid_o = vld_q[NORM_LAT-1];
  assign vec_o   = out_q;

endmodule

### rtl/core/vertex_transform_bake_unit.sv
// Vertex transform bake unit: position, normal and tangent baked through an affine transform.
// Throughput: one vertex word per clock; busy is never raised and every stage moves each cycle.
// Most of the pipeline lies in the two normalisers, each a 31-stage square root and a 15-stage divider.
// Reset (rst_ni low, asynchronous) clears all valid bits and loads the identity transform,
// zero translation and a determinant threshold of seven.
module vertex_transform_bake_unit import vtb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] position_x_i,
  input  logic signed [31:0] position_y_i,
  input  logic signed [31:0] position_z_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  input  logic signed [15:0] tangent_x_i,
  input  logic signed [15:0] tangent_y_i,
  input  logic signed [15:0] tangent_z_i,
  input  logic signed [15:0] handedness_i,
  output logic               result_valid_o,
  output logic signed [31:0] out_position_x_o,
  output logic signed [31:0] out_position_y_o,
  output logic signed [31:0] out_position_z_o,
  output logic signed [15:0] out_normal_x_o,
  output logic signed [15:0] out_normal_y_o,
  output logic signed [15:0] out_normal_z_o,
  output logic signed [15:0] out_tangent_x_o,
  output logic signed [15:0] out_tangent_y_o,
  output logic signed [15:0] out_tangent_z_o,
  output logic signed [15:0] out_handedness_o,
  output logic               mirrored_o,
  output logic               singular_o
);

  // Words that ride alongside the first normaliser.
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][33:0] mt;
    logic [15:0]      hand;
    logic             mir;
    logic             sing;
    logic             zero_n;
  } side1_t;

  // Words that ride alongside the second normaliser.
  typedef struct packed {
    logic [2:0][31:0] pos;
    uvec_t            nrm;
    logic [15:0]      hand;
    logic             mir;
    logic             sing;
    logic             short_t;
  } side2_t;

  // ---------------------------------------------------------------------------------------
  // Configuration registers. Writes land on the access phase; reads are combinational.
  // ---------------------------------------------------------------------------------------
  logic [47:0] row_q [3];
  logic [31:0] tr_q [3];
  logic [39:0] min_det_q;
  cfg_reg_e    cfg_sel;

  assign cfg_sel = cfg_reg_e'(paddr[5:3]);
  assign pready  = 1'b1;
  assign busy    = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0]  <= ROW0_RST;
      row_q[1]  <= ROW1_RST;
      row_q[2]  <= ROW2_RST;
      tr_q[0]   <= '0;
      tr_q[1]   <= '0;
      tr_q[2]   <= '0;
      min_det_q <= MIN_DET_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (cfg_sel)
        REG_ROW0:    row_q[0]  <= pwdata[47:0];
        REG_ROW1:    row_q[1]  <= pwdata[47:0];
        REG_ROW2:    row_q[2]  <= pwdata[47:0];
        REG_TR_X:    tr_q[0]   <= pwdata[31:0];
        REG_TR_Y:    tr_q[1]   <= pwdata[31:0];
        REG_TR_Z:    tr_q[2]   <= pwdata[31:0];
        REG_MIN_DET: min_det_q <= pwdata[39:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_ROW0:    prdata = {16'b0, row_q[0]};
      REG_ROW1:    prdata = {16'b0, row_q[1]};
      REG_ROW2:    prdata = {16'b0, row_q[2]};
      REG_TR_X:    prdata = {32'b0, tr_q[0]};
      REG_TR_Y:    prdata = {32'b0, tr_q[1]};
      REG_TR_Z:    prdata = {32'b0, tr_q[2]};
      REG_MIN_DET: prdata = {24'b0, min_det_q};
      default:     prdata = '0;
    endcase
  end

  // The matrix as signed Q4.12 coefficients. The user must change configuration only while the
  // pipeline is empty; the block does not enforce this, and every stage reads it directly.
  logic signed [15:0] m [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m[i][j] = $signed(row_q[i][16*j +: 16]);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Front end. Stage 0 captures the word; stages 1 to 5 build the cofactors, the
  // determinant, the transformed position, linear*t and the cofactor normal.
  // ---------------------------------------------------------------------------------------
  logic [5:0] fr_vld_q;

  logic signed [31:0] s0_p_q [3];
  logic signed [15:0] s0_n_q [3];
  logic signed [15:0] s0_t_q [3];
  logic signed [15:0] s0_h_q;

  logic signed [31:0] s1_cpa_q [3][3];
  logic signed [31:0] s1_cpb_q [3][3];
  logic signed [47:0] s1_pp_q [3][3];
  logic signed [31:0] s1_tp_q [3][3];
  logic signed [15:0] s1_n_q [3];
  logic signed [15:0] s1_h_q;

  logic signed [32:0] s2_cof_q [3][3];
  logic signed [49:0] s2_ps_q [3];
  logic signed [33:0] s2_mt_q [3];
  logic signed [15:0] s2_n_q [3];
  logic signed [15:0] s2_h_q;

  logic signed [48:0] s3_dp_q [3];
  logic signed [48:0] s3_np_q [3][3];
  logic signed [31:0] s3_pos_q [3];
  logic signed [33:0] s3_mt_q [3];
  logic signed [15:0] s3_h_q;

  logic signed [50:0] s4_det_q;
  logic signed [50:0] s4_cn_q [3];
  logic signed [31:0] s4_pos_q [3];
  logic signed [33:0] s4_mt_q [3];
  logic signed [15:0] s4_h_q;

  nvec_t  s5_vec_q;
  side1_t s5_side_q;

  // Position: round the Q20.28 sum to Q16.16, add the translation and saturate.
  logic signed [50:0] pos_rnd [3];
  logic signed [51:0] pos_sum [3];
  logic signed [31:0] pos_sat [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_rnd[i] = s2_ps_q[i];
      pos_rnd[i] = (pos_rnd[i] + 51'sd2048) >>> 12;
      pos_sum[i] = pos_rnd[i];
      pos_sum[i] = pos_sum[i] + $signed(tr_q[i]);
      if (pos_sum[i] > 52'sd2147483647) begin
        pos_sat[i] = 32'sh7fff_ffff;
      end else if (pos_sum[i] < -52'sd2147483648) begin
        pos_sat[i] = 32'sh8000_0000;
      end else begin
        pos_sat[i] = pos_sum[i][31:0];
      end
    end
  end

  // Determinant sign and threshold, and the cofactor normal with the mirror sign applied.
  logic              mir5;
  logic              sing5;
  logic [50:0]       det_mag5;
  logic signed [NORM_W-1:0] cn5 [3];
  logic              zero_n5;
  side1_t            side5;

  always_comb begin
    mir5     = s4_det_q[50];
    det_mag5 = mir5 ? 51'(-s4_det_q) : 51'(s4_det_q);
    sing5    = det_mag5 < 51'(min_det_q);
    zero_n5  = 1'b1;
    for (int i = 0; i < 3; i++) begin
      cn5[i] = s4_cn_q[i];
      if (mir5) cn5[i] = -cn5[i];
      if (s4_cn_q[i] != '0) zero_n5 = 1'b0;
    end
    for (int i = 0; i < 3; i++) begin
      side5.pos[i] = s4_pos_q[i];
      side5.mt[i]  = s4_mt_q[i];
    end
    side5.hand   = s4_h_q;
    side5.mir    = mir5;
    side5.sing   = sing5;
    side5.zero_n = zero_n5;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_vld_q <= '0;
    end else begin
      fr_vld_q <= {fr_vld_q[4:0], start && !busy};
    end
  end

  always_ff @(posedge clk_i) begin
    s0_p_q[0] <= position_x_i;
    s0_p_q[1] <= position_y_i;
    s0_p_q[2] <= position_z_i;
    s0_n_q[0] <= normal_x_i;
    s0_n_q[1] <= normal_y_i;
    s0_n_q[2] <= normal_z_i;
    s0_t_q[0] <= tangent_x_i;
    s0_t_q[1] <= tangent_y_i;
    s0_t_q[2] <= tangent_z_i;
    s0_h_q    <= handedness_i;

    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s1_cpa_q[i][j] <= m[NXT1[i]][NXT1[j]] * m[NXT2[i]][NXT2[j]];
        s1_cpb_q[i][j] <= m[NXT1[i]][NXT2[j]] * m[NXT2[i]][NXT1[j]];
        s1_pp_q[i][j]  <= m[i][j] * s0_p_q[j];
        s1_tp_q[i][j]  <= m[i][j] * s0_t_q[j];
      end
    end
    s1_n_q <= s0_n_q;
    s1_h_q <= s0_h_q;

    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s2_cof_q[i][j] <= 33'(s1_cpa_q[i][j]) - 33'(s1_cpb_q[i][j]);
      end
      s2_ps_q[i] <= 50'(s1_pp_q[i][0]) + 50'(s1_pp_q[i][1]) + 50'(s1_pp_q[i][2]);
      s2_mt_q[i] <= 34'(s1_tp_q[i][0]) + 34'(s1_tp_q[i][1]) + 34'(s1_tp_q[i][2]);
    end
    s2_n_q <= s1_n_q;
    s2_h_q <= s1_h_q;

    for (int i = 0; i < 3; i++) begin
      s3_dp_q[i] <= m[0][i] * s2_cof_q[0][i];
      for (int j = 0; j < 3; j++) begin
        s3_np_q[i][j] <= s2_cof_q[i][j] * s2_n_q[j];
      end
    end
    s3_pos_q <= pos_sat;
    s3_mt_q  <= s2_mt_q;
    s3_h_q   <= s2_h_q;

    s4_det_q <= 51'(s3_dp_q[0]) + 51'(s3_dp_q[1]) + 51'(s3_dp_q[2]);
    for (int i = 0; i < 3; i++) begin
      s4_cn_q[i] <= 51'(s3_np_q[i][0]) + 51'(s3_np_q[i][1]) + 51'(s3_np_q[i][2]);
    end
    s4_pos_q <= s3_pos_q;
    s4_mt_q  <= s3_mt_q;
    s4_h_q   <= s3_h_q;

    for (int i = 0; i < 3; i++) begin
      s5_vec_q[i] <= cn5[i];
    end
    s5_side_q <= side5;
  end

  // ---------------------------------------------------------------------------------------
  // First normaliser: the normal. The side words travel in a delay line of equal length.
  // ---------------------------------------------------------------------------------------
  logic   n1_vld;
  uvec_t  n1_vec;
  side1_t d1_q [NORM_LAT];

  vtb_norm u_norm_n (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_vld_q[5]),
    .vec_i   (s5_vec_q),
    .valid_o (n1_vld),
    .vec_o   (n1_vec)
  );

  always_ff @(posedge clk_i) begin
    d1_q[0] <= s5_side_q;
    for (int k = 1; k < NORM_LAT; k++) begin
      d1_q[k] <= d1_q[k-1];
    end
  end

  // ---------------------------------------------------------------------------------------
  // Tangent stages T1 to T7: fall back on a zero normal, project linear*t onto the plane of
  // the new normal and decide whether what is left is too short to normalise.
  // ---------------------------------------------------------------------------------------
  logic [6:0] tg_vld_q;

  logic signed [15:0] t1_nrm_q [3];
  side1_t             t1_side_q;

  logic signed [49:0] t2_dp_q [3];
  logic signed [15:0] t2_nrm_q [3];
  side1_t             t2_side_q;

  logic signed [37:0] t3_d_q;
  logic signed [15:0] t3_nrm_q [3];
  side1_t             t3_side_q;

  logic signed [53:0] t4_pd_q [3];
  logic signed [15:0] t4_nrm_q [3];
  side1_t             t4_side_q;

  logic signed [40:0] t5_pt_q [3];
  logic signed [15:0] t5_nrm_q [3];
  side1_t             t5_side_q;

  logic [31:0]        t6_sq_q [3];
  logic               t6_small_q;
  logic signed [40:0] t6_pt_q [3];
  logic signed [15:0] t6_nrm_q [3];
  side1_t             t6_side_q;

  nvec_t  t7_vec_q;
  side2_t t7_side_q;

  logic signed [51:0] dot3;
  logic signed [51:0] d3_full;
  logic signed [54:0] prj5 [3];
  logic signed [40:0] pt_mag6 [3];
  logic               small6;
  logic [33:0]        len7;
  side2_t             side7;

  always_comb begin
    dot3 = 52'(t2_dp_q[0]) + 52'(t2_dp_q[1]) + 52'(t2_dp_q[2]);
    d3_full = (dot3 + 52'sd8192) >>> 14;
    for (int i = 0; i < 3; i++) begin
      prj5[i] = t4_pd_q[i];
      prj5[i] = (prj5[i] + 55'sd8192) >>> 14;
    end
    small6 = 1'b1;
    for (int i = 0; i < 3; i++) begin
      pt_mag6[i] = t5_pt_q[i][40] ? -t5_pt_q[i] : t5_pt_q[i];
      if (pt_mag6[i] > 41'sd65535) small6 = 1'b0;
    end
    len7 = 34'(t6_sq_q[0]) + 34'(t6_sq_q[1]) + 34'(t6_sq_q[2]);
    for (int i = 0; i < 3; i++) begin
      side7.pos[i] = t6_side_q.pos[i];
      side7.nrm[i] = t6_nrm_q[i];
    end
    side7.hand    = t6_side_q.hand;
    side7.mir     = t6_side_q.mir;
    side7.sing    = t6_side_q.sing;
    side7.short_t = t6_small_q && (len7 <= TAN_EPS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tg_vld_q <= '0;
    end else begin
      tg_vld_q <= {tg_vld_q[5:0], n1_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      t1_nrm_q[i] <= d1_q[NORM_LAT-1].zero_n ? ((i == 1) ? VEC_ONE : 16'sd0)
                                             : $signed(n1_vec[i]);
    end
    t1_side_q <= d1_q[NORM_LAT-1];

    for (int i = 0; i < 3; i++) begin
      t2_dp_q[i] <= t1_nrm_q[i] * $signed(t1_side_q.mt[i]);
    end
    t2_nrm_q  <= t1_nrm_q;
    t2_side_q <= t1_side_q;

    t3_d_q    <= d3_full[37:0];
    t3_nrm_q  <= t2_nrm_q;
    t3_side_q <= t2_side_q;

    for (int i = 0; i < 3; i++) begin
      t4_pd_q[i] <= t3_nrm_q[i] * t3_d_q;
    end
    t4_nrm_q  <= t3_nrm_q;
    t4_side_q <= t3_side_q;

    for (int i = 0; i < 3; i++) begin
      t5_pt_q[i] <= 41'($signed(t4_side_q.mt[i])) - prj5[i][40:0];
    end
    t5_nrm_q  <= t4_nrm_q;
    t5_side_q <= t4_side_q;

    for (int i = 0; i < 3; i++) begin
      t6_sq_q[i] <= pt_mag6[i][15:0] * pt_mag6[i][15:0];
    end
    t6_small_q <= small6;
    t6_pt_q    <= t5_pt_q;
    t6_nrm_q   <= t5_nrm_q;
    t6_side_q  <= t5_side_q;

    for (int i = 0; i < 3; i++) begin
      t7_vec_q[i] <= NORM_W'(t6_pt_q[i]);
    end
    t7_side_q <= side7;
  end

  // ---------------------------------------------------------------------------------------
  // Second normaliser: the tangent.
  // ---------------------------------------------------------------------------------------
  logic   n2_vld;
  uvec_t  n2_vec;
  side2_t d2_q [NORM_LAT];

  vtb_norm u_norm_t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (tg_vld_q[6]),
    .vec_i   (t7_vec_q),
    .valid_o (n2_vld),
    .vec_o   (n2_vec)
  );

  always_ff @(posedge clk_i) begin
    d2_q[0] <= t7_side_q;
    for (int k = 1; k < NORM_LAT; k++) begin
      d2_q[k] <= d2_q[k-1];
    end
  end

  // ---------------------------------------------------------------------------------------
  // Output register. A singular transform zeroes the vectors and the handedness; a mirrored
  // one negates the handedness, with the most negative word saturating to the largest.
  // ---------------------------------------------------------------------------------------
  side2_t             fin;
  logic signed [15:0] tan_f [3];
  logic signed [15:0] hand_f;
  logic               out_vld_q;
  logic signed [31:0] out_pos_q [3];
  logic signed [15:0] out_nrm_q [3];
  logic signed [15:0] out_tan_q [3];
  logic signed [15:0] out_hand_q;
  logic               out_mir_q;
  logic               out_sing_q;

  always_comb begin
    fin = d2_q[NORM_LAT-1];
    for (int i = 0; i < 3; i++) begin
      tan_f[i] = fin.short_t ? ((i == 0) ? VEC_ONE : 16'sd0) : $signed(n2_vec[i]);
    end
    if (!fin.mir) begin
      hand_f = $signed(fin.hand);
    end else if (fin.hand == 16'h8000) begin
      hand_f = 16'sh7fff;
    end else begin
      hand_f = -$signed(fin.hand);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= n2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      out_pos_q[i] <= $signed(fin.pos[i]);
      out_nrm_q[i] <= fin.sing ? 16'sd0 : $signed(fin.nrm[i]);
      out_tan_q[i] <= fin.sing ? 16'sd0 : tan_f[i];
    end
    out_hand_q <= fin.sing ? 16'sd0 : hand_f;
    out_mir_q  <= fin.mir;
    out_sing_q <= fin.sing;
  end

  assign result_valid_o   = out_vld_q;
  assign out_position_x_o = out_pos_q[0];
  assign out_position_y_o = out_pos_q[1];
  assign out_position_z_o = out_pos_q[2];
  assign out_normal_x_o   = out_nrm_q[0];
  assign out_normal_y_o   = out_nrm_q[1];
  assign out_normal_z_o   = out_nrm_q[2];
  assign out_tangent_x_o  = out_tan_q[0];
  assign out_tangent_y_o  = out_tan_q[1];
  assign out_tangent_z_o  = out_tan_q[2];
  assign out_handedness_o = out_hand_q;
  assign mirrored_o       = out_mir_q;
  assign singular_o       = out_sing_q;

`ifndef SYNTHESIS
  // Every accepted word leaves after exactly the pipeline length.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##TOTAL_LAT result_valid_o)
    else $error("accepted word did not produce a result on time");

  // A singular transform gives zero vectors and zero handedness.
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && singular_o |->
      out_normal_x_o == 16'sd0 && out_normal_y_o == 16'sd0 && out_normal_z_o == 16'sd0 &&
      out_tangent_x_o == 16'sd0 && out_tangent_y_o == 16'sd0 &&
      out_tangent_z_o == 16'sd0 && out_handedness_o == 16'sd0)
    else $error("singular result carries non-zero vectors");

  // Otherwise the normal is a unit vector and so never all zero.
  a_normal_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !singular_o |->
      out_normal_x_o != 16'sd0 || out_normal_y_o != 16'sd0 || out_normal_z_o != 16'sd0)
    else $error("non-singular result has a zero normal");
`endif

endmodule
